// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Masking key size and the width of an index into it
	localparam int unsigned KEY_BYTES = 4;
	localparam int unsigned KEY_IDX_W = $clog2(KEY_BYTES);
	localparam int unsigned LEFT_W    = 4;

	// Seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE_16 = 7'h7E;
	localparam logic [6:0] LEN_CODE_64 = 7'h7F;

	// Extended length sizes in bytes
	localparam logic [LEFT_W-1:0] EXT_BYTES_16 = LEFT_W'(2);
	localparam logic [LEFT_W-1:0] EXT_BYTES_64 = LEFT_W'(8);

	// Per-item status codes carried on tuser
	typedef logic [1:0] status_t;
	localparam status_t ST_HEADER    = 2'd0;
	localparam status_t ST_HDR_DATA  = 2'd1;
	localparam status_t ST_PAYLOAD   = 2'd2;
	localparam status_t ST_HDR_EMPTY = 2'd3;

	// Output tdata layout, lowest bit first
	localparam int unsigned TDATA_FIELDS_W = 8 + 1 + 3 + 4 + 1 + 64;
	localparam int unsigned TDATA_W        = ((TDATA_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a WebSocket byte stream, unmasks payload bytes and reports one
// status item per input byte.
// ----------------------------------------------------------------------------
// Path: the input register takes the byte at the accept edge; one parse pass
//   then loads the output register once that register is empty or taken.
// Throughput: 1 byte per cycle while the output is not stalled; the parse
//   state update is a single pass.
// Reset: arst_n clears the parse state and both valid flags at once; the
//   masking key registers are not reset.
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
	// output stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] data_out, [8] fin_flag,
	                                           // [11:9] reserved_bits,
	                                           // [15:12] opcode, [16] is_masked,
	                                           // [80:17] payload_length, zero pad
	output logic [1:0]         m_axis_tuser,   // [1:0] status
	output logic               m_axis_tlast    // frame_end
);

	// Parse phases
	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parse state
	logic [2:0]           phase_q;
	logic [7:0]           first_q;
	logic                 masked_q;
	logic [LEFT_W-1:0]    left_q;
	logic [63:0]          len_q;
	logic [63:0]          rem_q;
	logic [KEY_IDX_W-1:0] pidx_q;
	logic [7:0]           key_q [KEY_BYTES];

	// Output register
	logic       out_valid_q;
	status_t    out_status_q;
	logic [7:0] out_data_q;
	logic [7:0] out_first_q;
	logic       out_masked_q;
	logic [63:0] out_len_q;
	logic       out_end_q;

	// Next-state values
	logic [2:0]           phase_n;
	logic [7:0]           first_n;
	logic                 masked_n;
	logic [LEFT_W-1:0]    left_n;
	logic [63:0]          len_n;
	logic [63:0]          rem_n;
	logic [KEY_IDX_W-1:0] pidx_n;
	status_t              status_n;
	logic [7:0]           data_n;
	logic                 end_n;
	logic                 key_we;
	logic [KEY_IDX_W:0]   key_pos;
	logic                 do_after;
	logic                 do_close;

	// Handshake: output register frees when empty or taken
	logic out_free;
	logic fire_s1;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Key slot addressed while collecting the masking key
	assign key_pos = (KEY_IDX_W+1)'(KEY_BYTES) - (KEY_IDX_W+1)'(left_q);

	// Parse pass for the byte in the input register
	always_comb begin
		phase_n  = phase_q;
		first_n  = first_q;
		masked_n = masked_q;
		left_n   = left_q;
		len_n    = len_q;
		rem_n    = rem_q;
		pidx_n   = pidx_q;
		status_n = ST_HEADER;
		data_n   = byte_s1;
		end_n    = 1'b0;
		key_we   = 1'b0;
		do_after = 1'b0;
		do_close = 1'b0;

		unique case (phase_q)
			PH_SECOND: begin
				masked_n = byte_s1[7];
				len_n    = '0;
				if (byte_s1[6:0] == LEN_CODE_16) begin
					left_n  = EXT_BYTES_16;
					phase_n = PH_EXTLEN;
				end else if (byte_s1[6:0] == LEN_CODE_64) begin
					left_n  = EXT_BYTES_64;
					phase_n = PH_EXTLEN;
				end else begin
					len_n    = 64'(byte_s1[6:0]);
					do_after = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_n  = {len_q[55:0], byte_s1};
				left_n = (left_q == '0) ? '0 : left_q - LEFT_W'(1);
				if (left_n == '0) begin
					do_after = 1'b1;
				end
			end
			PH_KEY: begin
				key_we = (key_pos < (KEY_IDX_W+1)'(KEY_BYTES));
				left_n = (left_q == '0) ? '0 : left_q - LEFT_W'(1);
				if (left_n == '0) begin
					do_close = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (masked_q) begin
					data_n = byte_s1 ^ key_q[pidx_q];
				end
				pidx_n   = pidx_q + KEY_IDX_W'(1);
				rem_n    = rem_q - 64'd1;
				status_n = ST_PAYLOAD;
				if (rem_q == 64'd1) begin
					end_n   = 1'b1;
					phase_n = PH_FIRST;
				end
			end
			default: begin
				first_n  = byte_s1;
				masked_n = 1'b0;
				left_n   = '0;
				len_n    = '0;
				pidx_n   = '0;
				phase_n  = PH_SECOND;
			end
		endcase

		// Length known: collect the key, or finish the header
		if (do_after && masked_n) begin
			left_n  = LEFT_W'(KEY_BYTES);
			phase_n = PH_KEY;
		end else if (do_after || do_close) begin
			if (len_n == '0) begin
				end_n    = 1'b1;
				phase_n  = PH_FIRST;
				status_n = ST_HDR_EMPTY;
			end else begin
				pidx_n   = '0;
				rem_n    = len_n;
				phase_n  = PH_PAYLOAD;
				status_n = ST_HDR_DATA;
			end
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			first_q  <= '0;
			masked_q <= 1'b0;
			left_q   <= '0;
			len_q    <= '0;
			rem_q    <= '0;
			pidx_q   <= '0;
		end else if (fire_s1) begin
			phase_q  <= phase_n;
			first_q  <= first_n;
			masked_q <= masked_n;
			left_q   <= left_n;
			len_q    <= len_n;
			rem_q    <= rem_n;
			pidx_q   <= pidx_n;
		end
	end

	// Masking key store, written as key bytes arrive
	always_ff @(posedge clk) begin
		if (fire_s1 && key_we) begin
			key_q[key_pos[KEY_IDX_W-1:0]] <= byte_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_status_q <= status_n;
			out_data_q   <= data_n;
			out_first_q  <= first_n;
			out_masked_q <= masked_n;
			out_len_q    <= (status_n == ST_HEADER) ? 64'd0 : len_n;
			out_end_q    <= end_n;
		end
	end

	// Output packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tdata  = TDATA_W'({out_len_q, out_masked_q, out_first_q[3:0],
	                                 out_first_q[6:4], out_first_q[7], out_data_q});

endmodule

// ===== rtl/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the WebSocket frame deframer, bound to its top level.
// ----------------------------------------------------------------------------
module wsd_checker
	import wsd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]         m_axis_tuser,
	input logic               m_axis_tlast
);

	// Stalled output item holds its content
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// Length reads zero until the header is done
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_HEADER |-> m_axis_tdata[80:17] == 64'd0)
		else $error("length shown before header complete");

	// Empty frame header closes the frame, a header with payload does not
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_HDR_EMPTY |->
			m_axis_tlast && m_axis_tdata[80:17] == 64'd0)
		else $error("empty frame header without frame end");

	a_data_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_HDR_DATA |->
			!m_axis_tlast && m_axis_tdata[80:17] != 64'd0)
		else $error("header with payload marked as frame end");

	// Padding bits above the fields stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:TDATA_FIELDS_W] == '0)
		else $error("tdata padding not zero");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/websocket_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test
// Streams WebSocket frames (short, 16-bit and 64-bit lengths, masked and
// unmasked, empty and non-empty) into the deframer. A local parser predicts
// the status item of every accepted byte, and each output item is checked
// against it. Both stream sides idle at random, and one long output stall
// backs the block up.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test;
	import wsd_pkg::*;

	localparam int unsigned CALM_TAIL      = 150;  // last bytes sent with no idling
	localparam int unsigned HOLD_AFTER     = 300;  // bytes in before the long stall
	localparam int unsigned HOLD_CYCLES    = 80;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES   = 20;

	typedef enum logic [2:0] {
		PARSE_FIRST, PARSE_SECOND, PARSE_EXTLEN, PARSE_KEY, PARSE_PAYLOAD
	} parse_at_t;

	typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	typedef struct {
		status_t     status;
		logic [7:0]  data;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic        frame_end;
	} frame_status_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;   // [7:0] data_out, [8] fin_flag,
	                                    // [11:9] reserved_bits, [15:12] opcode,
	                                    // [16] is_masked, [80:17] payload_length
	logic [1:0]         m_axis_tuser;   // [1:0] status
	logic               m_axis_tlast;   // frame_end

	// Parser model state
	parse_at_t   parse_at = PARSE_FIRST;
	logic [7:0]  hdr_byte = 8'h00;
	logic        key_on = 1'b0;
	logic [3:0]  bytes_left = 4'd0;
	logic [63:0] frame_len = 64'd0;
	logic [7:0]  key_bytes [KEY_BYTES];
	logic [63:0] payload_idx = 64'd0;

	// Stimulus and scoreboard
	logic [7:0]    stream_bytes [$];
	frame_status_t status_items_due [$];
	int unsigned   total_bytes = 0;
	int unsigned   bytes_accepted = 0;
	int unsigned   mismatches = 0;
	int unsigned   idle_cycles = 0;
	bit            byte_taken = 1'b0;
	bit            item_taken = 1'b0;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	int unsigned   hold_left = 0;
	bit            hold_done = 1'b0;

	websocket_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	// header finished: empty frame ends here, otherwise payload follows
	function automatic void close_header(inout frame_status_t r);
		if (frame_len == 64'd0) begin
			r.status    = ST_HDR_EMPTY;
			r.frame_end = 1'b1;
			parse_at    = PARSE_FIRST;
		end else begin
			r.status    = ST_HDR_DATA;
			payload_idx = 64'd0;
			parse_at    = PARSE_PAYLOAD;
		end
	endfunction

	// length known: collect the key first if the frame is masked
	function automatic void length_known(inout frame_status_t r);
		if (key_on) begin
			bytes_left = 4'(KEY_BYTES);
			parse_at   = PARSE_KEY;
		end else begin
			close_header(r);
		end
	endfunction

	function automatic frame_status_t parse_byte(logic [7:0] b);
		frame_status_t r;
		logic [6:0]    code;
		int unsigned   idx;
		r.status    = ST_HEADER;
		r.data      = b;
		r.frame_end = 1'b0;
		case (parse_at)
			PARSE_SECOND: begin
				key_on    = b[7];
				code      = b[6:0];
				frame_len = 64'd0;
				if (code == LEN_CODE_16) begin
					bytes_left = EXT_BYTES_16;
					parse_at   = PARSE_EXTLEN;
				end else if (code == LEN_CODE_64) begin
					bytes_left = EXT_BYTES_64;
					parse_at   = PARSE_EXTLEN;
				end else begin
					frame_len = 64'(code);
					length_known(r);
				end
			end
			PARSE_EXTLEN: begin
				frame_len = {frame_len[55:0], b};
				if (bytes_left != 0) bytes_left--;
				if (bytes_left == 0) length_known(r);
			end
			PARSE_KEY: begin
				idx = KEY_BYTES - bytes_left;
				if (idx < KEY_BYTES) key_bytes[idx] = b;
				if (bytes_left != 0) bytes_left--;
				if (bytes_left == 0) close_header(r);
			end
			PARSE_PAYLOAD: begin
				idx = int'(payload_idx % KEY_BYTES);
				if (key_on) r.data = b ^ key_bytes[idx];
				payload_idx++;
				r.status = ST_PAYLOAD;
				if (payload_idx >= frame_len) begin
					r.frame_end = 1'b1;
					parse_at    = PARSE_FIRST;
				end
			end
			default: begin
				hdr_byte    = b;
				key_on      = 1'b0;
				bytes_left  = 4'd0;
				frame_len   = 64'd0;
				payload_idx = 64'd0;
				parse_at    = PARSE_SECOND;
			end
		endcase
		r.fin    = hdr_byte[7];
		r.rsv    = hdr_byte[6:4];
		r.opcode = hdr_byte[3:0];
		r.masked = key_on;
		r.length = (r.status == ST_HEADER) ? 64'd0 : frame_len;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// queue one frame; n_payload may fall short of len for a cut-off frame
	task automatic add_frame(logic [7:0] first, logic masked, logic [31:0] key,
	                         len_form_t form, logic [63:0] len, int n_payload);
		logic [6:0] code;
		case (form)
			LEN_EXT16: code = LEN_CODE_16;
			LEN_EXT64: code = LEN_CODE_64;
			default:   code = len[6:0];
		endcase
		stream_bytes.push_back(first);
		stream_bytes.push_back({masked, code});
		if (form == LEN_EXT16) begin
			stream_bytes.push_back(len[15:8]);
			stream_bytes.push_back(len[7:0]);
		end else if (form == LEN_EXT64) begin
			for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--) stream_bytes.push_back(key[8*i +: 8]);
		end
		for (int i = 0; i < n_payload; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_random_frame();
		len_form_t   form;
		logic [63:0] len;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			form = LEN_SHORT;
			len  = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
			                                       : $urandom_range(0, 12));
		end else if (pick < 8) begin
			form = LEN_EXT16;
			len  = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
			                                       : $urandom_range(0, 20));
		end else begin
			form = LEN_EXT64;
			len  = 64'($urandom_range(0, 20));
		end
		add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom,
		          form, len, int'(len));
	endtask

	// ------------------------------------------------------------------
	// Input driver: presents queued bytes, with random gap bursts
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (stream_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 5) - 1;
				s_axis_tvalid <= 1'b0;
			end else if (stream_bytes.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= stream_bytes.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output ready: random stall bursts plus one long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (stream_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on input accept, checks on output accept
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		frame_status_t want;
		byte_taken = arst_n && s_axis_tvalid && s_axis_tready;
		item_taken = arst_n && m_axis_tvalid && m_axis_tready;
		if (byte_taken) begin
			status_items_due.push_back(parse_byte(s_axis_tdata));
			bytes_accepted++;
		end
		if (item_taken) begin
			if (status_items_due.size() == 0) begin
				$error("output item with nothing expected");
				mismatches++;
			end else begin
				want = status_items_due.pop_front();
				check_field("status", want.status, m_axis_tuser);
				check_field("data_out", want.data, m_axis_tdata[7:0]);
				check_field("fin_flag", want.fin, m_axis_tdata[8]);
				check_field("reserved_bits", want.rsv, m_axis_tdata[11:9]);
				check_field("opcode", want.opcode, m_axis_tdata[15:12]);
				check_field("is_masked", want.masked, m_axis_tdata[16]);
				check_field("payload_length", want.length, m_axis_tdata[80:17]);
				check_field("tdata_pad", 64'd0, m_axis_tdata[TDATA_W-1:TDATA_FIELDS_W]);
				check_field("frame_end", want.frame_end, m_axis_tlast);
			end
		end
		if (byte_taken || item_taken) idle_cycles = 0;
		else if (arst_n) idle_cycles++;
	end

	// watchdog on cycles with no traffic at all
	initial begin
		wait (arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// directed: empty short frame, all header bits set with an all-ones
		// key, masked empty frame, extended 16-bit zero length, 64-bit length
		add_frame(8'h81, 1'b0, 32'h0, LEN_SHORT, 64'd0, 0);
		add_frame(8'hFF, 1'b1, 32'hFFFF_FFFF, LEN_SHORT, 64'd1, 1);
		add_frame(8'h00, 1'b1, 32'h0, LEN_SHORT, 64'd0, 0);
		add_frame(8'h02, 1'b0, 32'h0, LEN_EXT16, 64'd0, 0);
		add_frame(8'h88, 1'b0, 32'h0, LEN_EXT64, 64'd2, 2);
		// random frames
		while (stream_bytes.size() < 1420) add_random_frame();
		// largest 64-bit length, cut off after a few payload bytes
		add_frame(8'($urandom_range(0, 255)), 1'b1, $urandom, LEN_EXT64,
		          64'hFFFF_FFFF_FFFF_FFFF, 6);
		total_bytes = stream_bytes.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bytes_accepted < total_bytes) @(posedge clk);
		while (status_items_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
